[hdl/pam_pkg.sv]
`timescale 1ns / 1ps

package pam_pkg;

	// Fixed field widths.
	localparam int DIST_W   = 16;
	localparam int WEIGHT_W = 16;
	localparam int COST_W   = 40;
	localparam int DIFF_W   = DIST_W + 1;
	localparam int PROD_W   = WEIGHT_W + 1 + DIFF_W;
	localparam int MED_W    = 8;
	localparam int SLOT_W   = 4;

	// A run gives up after this many passes.
	localparam int PASS_LIMIT = 256;
	localparam int PASS_W     = 9;

	// Input item actions.
	localparam logic [2:0] ACT_DIST   = 3'd0;
	localparam logic [2:0] ACT_WEIGHT = 3'd1;
	localparam logic [2:0] ACT_MEDOID = 3'd2;
	localparam logic [2:0] ACT_RUN    = 3'd3;
	localparam logic [2:0] ACT_QUERY  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_NUM_ELEMENTS = 2'd0;
	localparam logic [1:0] CFG_NUM_CLUSTERS = 2'd1;
	localparam logic [1:0] CFG_MAX_DISTANCE = 2'd2;

	// One request to the shared multiply-accumulate unit.
	typedef struct packed {
		logic                     clr;
		logic                     en;
		logic [WEIGHT_W-1:0]      a;
		logic signed [DIFF_W-1:0] b;
	} mac_op_t;

endpackage

[hdl/pam_mac.sv]
`timescale 1ns / 1ps

// Shared multiply-accumulate unit: weight times signed distance difference,
// with one register after the multiplier and one on the accumulator.
module pam_mac #(
	parameter int ACC_W = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pam_pkg::mac_op_t        op,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [pam_pkg::PROD_W-1:0] prod_s1;
	logic                              vld_s1;
	logic signed [ACC_W-1:0]           acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= $signed({1'b0, op.a}) * op.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else if (op.clr) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= op.en;
			if (vld_s1) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	assign acc = acc_q;

endmodule

[hdl/pam_dist_mem.sv]
`timescale 1ns / 1ps

// Dense distance matrix, one port. Out-of-range coordinates ignore the write
// and read back as zero.
module pam_dist_mem #(
	parameter int MAX_ELEMENTS = 256,
	localparam int EW = $clog2(MAX_ELEMENTS),
	localparam int IW = (EW > 8) ? EW : 8,
	localparam int AW = $clog2(MAX_ELEMENTS * MAX_ELEMENTS)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [IW-1:0]              row,
	input  logic [IW-1:0]              col,
	input  logic [pam_pkg::DIST_W-1:0] wdata,
	output logic [pam_pkg::DIST_W-1:0] rdata
);

	logic [pam_pkg::DIST_W-1:0] mem [MAX_ELEMENTS * MAX_ELEMENTS];
	logic [pam_pkg::DIST_W-1:0] rd_q;
	logic                       oob_q;
	logic                       in_range;
	logic [AW-1:0]              addr;

	assign in_range = (32'(row) < MAX_ELEMENTS) && (32'(col) < MAX_ELEMENTS);
	assign addr = AW'(row[EW-1:0]) * AW'(MAX_ELEMENTS) + AW'(col[EW-1:0]);

	always_ff @(posedge clk) begin
		if (we && in_range) begin
			mem[addr] <= wdata;
		end
		rd_q  <= mem[addr];
		oob_q <= !in_range;
	end

	assign rdata = oob_q ? '0 : rd_q;

endmodule

[hdl/pam_swap_medoid_refine_core.sv]
`timescale 1ns / 1ps

// Channel   Signals                                           Direction
// input     in_valid/in_ready, action row column
//           medoid_slot_in value                              into block
// result    out_valid/out_ready, medoid_slot medoid_element
//           total_cost cluster_of_element last                out of block
// config    cfg_we cfg_index cfg_wdata                        into block, write only
//
// Load items (distance, weight, medoid) transfer back to back while no result is stalled.
// A query leaves one result in the output register.
// A run uses the single distance memory port and the one multiply-accumulate unit;
// its K results then leave one per cycle while out_ready is high. No input is taken
// during a run.
// Reset clears the sequencer, medoid list and assignment valid bits, and sets the configuration to its defaults.
// A stalled result holds in the output register; input is taken once it frees.
module pam_swap_medoid_refine_core #(
	parameter int MAX_ELEMENTS = 256,
	parameter int MAX_CLUSTERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  row,
	input  logic [7:0]  column,
	input  logic [3:0]  medoid_slot_in,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  medoid_slot,
	output logic [7:0]  medoid_element,
	output logic [39:0] total_cost,
	output logic [3:0]  cluster_of_element,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// Element index, element count, slot index and slot count widths.
	localparam int EW    = $clog2(MAX_ELEMENTS);
	localparam int IW    = (EW > 8) ? EW : 8;
	localparam int NW    = $clog2(MAX_ELEMENTS + 1);
	localparam int SW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int KW    = $clog2(MAX_CLUSTERS + 1);
	localparam int ACC_W = pam_pkg::PROD_W + EW + 8;
	localparam int DW    = pam_pkg::DIST_W;

	typedef enum logic [4:0] {
		ST_IDLE, ST_QUERY,
		ST_A_ROW, ST_A_RD, ST_A_USE,
		ST_C_RD, ST_C_USE, ST_C_END,
		ST_S_H, ST_K_RD, ST_K_USE,
		ST_Z_K, ST_Z_J, ST_Z_A, ST_Z_B, ST_Z_D1, ST_Z_CMP,
		ST_S_END, ST_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [8:0]  ne_q;
	logic [4:0]  nc_q;
	logic [DW-1:0] maxd_q;

	// Sequencer registers.
	logic [NW-1:0]  nrun_q, j_q, h_q;
	logic [KW-1:0]  kcr_q, k_q;
	logic [pam_pkg::PASS_W-1:0] pass_q;
	logic           first_q, upd_q;
	logic [DW-1:0]  nd_q, sd_q, dhj_q;
	logic [3:0]     bslot_q;
	logic [7:0]     i_q, nbest_q, hbest_q;
	logic signed [ACC_W-1:0] best_q;
	logic [39:0]    total_q;
	logic [7:0]     med_q [MAX_CLUSTERS];

	// Output register.
	logic        out_valid_q, last_q;
	logic [3:0]  slot_q, clus_q;
	logic [7:0]  elem_q;
	logic [39:0] cost_q;
	logic        out_load;

	// Memories and their read data.
	logic [DW-1:0] w_mem   [MAX_ELEMENTS];
	logic [DW-1:0] nd_mem  [MAX_ELEMENTS];
	logic [DW-1:0] sd_mem  [MAX_ELEMENTS];
	logic [3:0]    asg_mem [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] asg_vld_q;
	logic [DW-1:0] w_rd, nd_rd, sd_rd;
	logic [3:0]    asg_rd;
	logic          asg_ok;

	logic          in_fire, nd_we, w_we, dm_we;
	logic [IW-1:0] dm_row, dm_col;
	logic [DW-1:0] dm_rdata, s_min;
	logic [EW-1:0] rd_idx, q_idx;
	logic [7:0]    med_k;
	logic          k_done, j_done, h_done, row_ok;
	logic signed [ACC_W-1:0] acc;
	pam_pkg::mac_op_t mac_op;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;
	assign row_ok   = 32'(row) < MAX_ELEMENTS;
	assign rd_idx   = j_q[EW-1:0];
	assign q_idx    = EW'(row);
	assign med_k    = med_q[k_q[SW-1:0]];
	assign k_done   = k_q >= kcr_q;
	assign j_done   = j_q >= nrun_q;
	assign h_done   = h_q >= nrun_q;
	assign w_we     = in_fire && (action == pam_pkg::ACT_WEIGHT) && row_ok;
	assign s_min    = (sd_rd > dhj_q) ? dhj_q : sd_rd;

	// The output register takes a new result in this cycle.
	assign out_load = (state_q == ST_QUERY) ||
		((state_q == ST_EMIT) && !k_done && (!out_valid_q || out_ready));

	pam_dist_mem #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dist (
		.clk   (clk),
		.we    (dm_we),
		.row   (dm_row),
		.col   (dm_col),
		.wdata (value),
		.rdata (dm_rdata)
	);

	pam_mac #(.ACC_W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	// Distance port addressing, memory write strobes and requests to the
	// multiply-accumulate unit all follow the sequencer state.
	always_comb begin
		mac_op = '0;
		dm_we  = 1'b0;
		dm_row = IW'(j_q);
		dm_col = IW'(med_k);
		nd_we  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				dm_row = IW'(row);
				dm_col = IW'(column);
				dm_we  = in_fire && (action == pam_pkg::ACT_DIST);
			end
			ST_A_RD: begin
				nd_we = k_done;
			end
			ST_A_ROW: begin
				mac_op.clr = j_done && first_q;
			end
			ST_K_RD: begin
				dm_row = IW'(h_q);
			end
			ST_Z_K: begin
				mac_op.clr = !k_done;
			end
			ST_Z_J: begin
				dm_row = IW'(h_q);
				dm_col = IW'(j_q);
			end
			ST_Z_A: begin
				dm_row = IW'(i_q);
				dm_col = IW'(j_q);
			end
			ST_C_USE: begin
				mac_op.en = 1'b1;
				mac_op.a  = w_rd;
				mac_op.b  = $signed({1'b0, nd_rd});
			end
			ST_Z_B: begin
				// The swapped-out medoid served this element: it falls back to the
				// better of its second medoid and the candidate. Otherwise it moves
				// only when the candidate is strictly closer.
				mac_op.a = w_rd;
				if (dm_rdata == nd_rd) begin
					mac_op.en = 1'b1;
					mac_op.b  = $signed({1'b0, s_min}) - $signed({1'b0, nd_rd});
				end else if (dhj_q < nd_rd) begin
					mac_op.en = 1'b1;
					mac_op.b  = $signed({1'b0, dhj_q}) - $signed({1'b0, nd_rd});
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[q_idx] <= value;
		end
		if (nd_we) begin
			nd_mem[rd_idx] <= nd_q;
			sd_mem[rd_idx] <= sd_q;
		end
		if (nd_we && upd_q) begin
			asg_mem[rd_idx] <= bslot_q;
		end
		w_rd   <= w_mem[rd_idx];
		nd_rd  <= nd_mem[rd_idx];
		sd_rd  <= sd_mem[rd_idx];
		asg_rd <= asg_mem[q_idx];
		asg_ok <= asg_vld_q[q_idx] && row_ok;
	end

	// An assignment that was never written reads as slot zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asg_vld_q <= '0;
		end else if (nd_we && upd_q) begin
			asg_vld_q[rd_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q   <= 9'd256;
			nc_q   <= 5'd2;
			maxd_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pam_pkg::CFG_NUM_ELEMENTS: ne_q   <= cfg_wdata[8:0];
				pam_pkg::CFG_NUM_CLUSTERS: nc_q   <= cfg_wdata[4:0];
				pam_pkg::CFG_MAX_DISTANCE: maxd_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pass_q      <= '0;
			first_q     <= 1'b0;
			for (int s = 0; s < MAX_CLUSTERS; s++) begin
				med_q[s] <= '0;
			end
		end else begin
			if (out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (action)
							pam_pkg::ACT_MEDOID: begin
								for (int s = 0; s < MAX_CLUSTERS; s++) begin
									if (32'(medoid_slot_in) == s) begin
										med_q[s] <= value[7:0];
									end
								end
							end
							pam_pkg::ACT_RUN: begin
								nrun_q  <= (32'(ne_q) > MAX_ELEMENTS) ?
									NW'(MAX_ELEMENTS) : NW'(ne_q);
								kcr_q   <= (nc_q == '0) ? KW'(1) :
									((32'(nc_q) > MAX_CLUSTERS) ? KW'(MAX_CLUSTERS) :
									KW'(nc_q));
								first_q <= 1'b1;
								pass_q  <= '0;
								j_q     <= '0;
								state_q <= ST_A_ROW;
							end
							pam_pkg::ACT_QUERY: begin
								state_q <= ST_QUERY;
							end
							default: begin
							end
						endcase
					end
				end
				ST_QUERY: begin
					out_valid_q <= 1'b1;
					slot_q      <= '0;
					elem_q      <= '0;
					cost_q      <= '0;
					clus_q      <= asg_ok ? asg_rd : 4'd0;
					last_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				// Nearest and second-nearest search over the medoids, each read in ST_A_RD and used in ST_A_USE.
				ST_A_ROW: begin
					if (j_done) begin
						j_q <= '0;
						if (first_q) begin
							state_q <= ST_C_RD;
						end else begin
							h_q     <= '0;
							best_q  <= ACC_W'(1);
							state_q <= ST_S_H;
						end
					end else begin
						nd_q    <= maxd_q;
						sd_q    <= maxd_q;
						k_q     <= '0;
						upd_q   <= 1'b0;
						state_q <= ST_A_RD;
					end
				end
				ST_A_RD: begin
					if (k_done) begin
						j_q     <= j_q + NW'(1);
						state_q <= ST_A_ROW;
					end else begin
						state_q <= ST_A_USE;
					end
				end
				ST_A_USE: begin
					if (nd_q > dm_rdata) begin
						sd_q    <= nd_q;
						nd_q    <= dm_rdata;
						bslot_q <= 4'(k_q);
						upd_q   <= 1'b1;
					end else if (sd_q > dm_rdata) begin
						sd_q <= dm_rdata;
					end
					k_q     <= k_q + KW'(1);
					state_q <= ST_A_RD;
				end
				// Initial weighted cost, on the first pass only.
				ST_C_RD: begin
					state_q <= j_done ? ST_C_END : ST_C_USE;
				end
				ST_C_USE: begin
					j_q     <= j_q + NW'(1);
					state_q <= ST_C_RD;
				end
				ST_C_END: begin
					total_q <= acc[39:0];
					first_q <= 1'b0;
					h_q     <= '0;
					best_q  <= ACC_W'(1);
					state_q <= ST_S_H;
				end
				// Candidate loop: a candidate at distance zero from a medoid is skipped.
				ST_S_H: begin
					k_q     <= '0;
					state_q <= h_done ? ST_S_END : ST_K_RD;
				end
				ST_K_RD: begin
					if (k_done) begin
						k_q     <= '0;
						state_q <= ST_Z_K;
					end else begin
						state_q <= ST_K_USE;
					end
				end
				ST_K_USE: begin
					if (dm_rdata == '0) begin
						h_q     <= h_q + NW'(1);
						state_q <= ST_S_H;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= ST_K_RD;
					end
				end
				// Swap delta of this candidate against each medoid.
				ST_Z_K: begin
					if (k_done) begin
						h_q     <= h_q + NW'(1);
						state_q <= ST_S_H;
					end else begin
						i_q     <= med_k;
						j_q     <= '0;
						state_q <= ST_Z_J;
					end
				end
				ST_Z_J: begin
					state_q <= j_done ? ST_Z_D1 : ST_Z_A;
				end
				ST_Z_A: begin
					dhj_q   <= dm_rdata;
					state_q <= ST_Z_B;
				end
				ST_Z_B: begin
					j_q     <= j_q + NW'(1);
					state_q <= ST_Z_J;
				end
				ST_Z_D1: begin
					state_q <= ST_Z_CMP;
				end
				ST_Z_CMP: begin
					// Strictly smaller only, so the first minimum stays.
					if (best_q > acc) begin
						best_q  <= acc;
						hbest_q <= 8'(h_q);
						nbest_q <= i_q;
					end
					k_q     <= k_q + KW'(1);
					state_q <= ST_Z_K;
				end
				ST_S_END: begin
					if (best_q[ACC_W-1]) begin
						// Every active slot holding the old medoid takes the candidate.
						for (int s = 0; s < MAX_CLUSTERS; s++) begin
							if ((KW'(s) < kcr_q) && (med_q[s] == nbest_q)) begin
								med_q[s] <= hbest_q;
							end
						end
						total_q <= total_q + best_q[39:0];
					end
					pass_q <= pass_q + pam_pkg::PASS_W'(1);
					j_q    <= '0;
					k_q    <= '0;
					if (best_q[ACC_W-1] &&
						(pass_q != pam_pkg::PASS_W'(pam_pkg::PASS_LIMIT - 1))) begin
						state_q <= ST_A_ROW;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (k_done) begin
						state_q <= ST_IDLE;
					end else if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						slot_q      <= 4'(k_q);
						elem_q      <= med_k;
						cost_q      <= total_q;
						clus_q      <= '0;
						last_q      <= (k_q + KW'(1)) == kcr_q;
						k_q         <= k_q + KW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign medoid_slot        = slot_q;
	assign medoid_element     = elem_q;
	assign total_cost         = cost_q;
	assign cluster_of_element = clus_q;
	assign last               = last_q;

	// The slot count of a run lies in its legal range once the run has started.
	a_kc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_QUERY) |->
		(kcr_q != '0 && 32'(kcr_q) <= MAX_CLUSTERS))
		else $error("slot count of run out of range");

	// The pass counter stops at the pass limit.
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pass_q) <= pam_pkg::PASS_LIMIT)
		else $error("pass counter beyond limit");

	// A result carrying a cluster slot comes from a query and is always final.
	a_query_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clus_q != '0) |-> last_q)
		else $error("query result not marked last");

	// Input is refused whenever the sequencer is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");

endmodule
